### rtl/pip_pkg.sv
package pip_pkg;

  typedef logic [1:0] vcount_t;

  localparam vcount_t VCOUNT_NONE = 2'd0;
  localparam vcount_t VCOUNT_ONE  = 2'd1;
  localparam vcount_t VCOUNT_FULL = 2'd3;

endpackage

### rtl/point_in_polygon_even_odd.sv
// Even-odd point-in-polygon test over a stream of vertex words.
// The input register takes the word, and the result register is loaded from it.
// Throughput: one word per cycle; a held result word stalls input once the input reg is full.
// Per word: open and closing edge tests, four (COORD_BITS+1)-bit multiplies and two compares.
// Reset (rst, synchronous): empties both registers, closes any open query and clears
// the vertex count and both parities.
module point_in_polygon_even_odd #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] query_x,
  input  logic signed [COORD_BITS-1:0] query_y,
  input  logic signed [COORD_BITS-1:0] vertex_x,
  input  logic signed [COORD_BITS-1:0] vertex_y,
  input  logic                         last_vertex,
  input  logic                         last_polygon,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         inside_res
);
  import pip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;

  function automatic logic edge_cross(
    input logic signed [COORD_BITS-1:0] x0,
    input logic signed [COORD_BITS-1:0] y0,
    input logic signed [COORD_BITS-1:0] x1,
    input logic signed [COORD_BITS-1:0] y1,
    input logic signed [COORD_BITS-1:0] px,
    input logic signed [COORD_BITS-1:0] py
  );
    logic                         fwd;
    logic                         bwd;
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [DW-1:0]         d_py;
    logic signed [DW-1:0]         d_bx;
    logic signed [DW-1:0]         d_by;
    logic signed [DW-1:0]         d_px;
    logic signed [PW-1:0]         lhs;
    logic signed [PW-1:0]         rhs;
    fwd = (x0 < px) && (px <= x1);
    bwd = (x1 < px) && (px <= x0);
    ax = fwd ? x0 : x1;
    ay = fwd ? y0 : y1;
    bx = fwd ? x1 : x0;
    by = fwd ? y1 : y0;
    d_py = DW'(py) - DW'(ay);
    d_bx = DW'(bx) - DW'(ax);
    d_by = DW'(by) - DW'(ay);
    d_px = DW'(px) - DW'(ax);
    lhs = PW'(d_py) * PW'(d_bx);
    rhs = PW'(d_by) * PW'(d_px);
    return (fwd || bwd) && (lhs > rhs);
  endfunction

  logic                         s1_valid;
  logic signed [COORD_BITS-1:0] s1_qx;
  logic signed [COORD_BITS-1:0] s1_qy;
  logic signed [COORD_BITS-1:0] s1_vx;
  logic signed [COORD_BITS-1:0] s1_vy;
  logic                         s1_lv;
  logic                         s1_lp;

  logic signed [COORD_BITS-1:0] point_reg_x;
  logic signed [COORD_BITS-1:0] point_reg_y;
  logic signed [COORD_BITS-1:0] first_vertex_x;
  logic signed [COORD_BITS-1:0] first_vertex_y;
  logic signed [COORD_BITS-1:0] prev_vertex_x;
  logic signed [COORD_BITS-1:0] prev_vertex_y;
  vcount_t                      vertex_count;
  logic                         crossing_parity;
  logic                         polygon_parity;
  logic                         query_open;

  logic                         s1_adv;
  logic signed [COORD_BITS-1:0] px;
  logic signed [COORD_BITS-1:0] py;
  logic                         first_item;
  logic signed [COORD_BITS-1:0] fx;
  logic signed [COORD_BITS-1:0] fy;
  logic                         open_cross;
  logic                         close_cross;
  logic                         parity_open;
  logic                         parity_close;
  vcount_t                      vertex_count_next;
  logic                         polygon_parity_next;

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_comb begin
    px          = query_open ? point_reg_x : s1_qx;
    py          = query_open ? point_reg_y : s1_qy;
    first_item  = (vertex_count == VCOUNT_NONE);
    fx          = first_item ? s1_vx : first_vertex_x;
    fy          = first_item ? s1_vy : first_vertex_y;
    open_cross  = edge_cross(prev_vertex_x, prev_vertex_y, s1_vx, s1_vy, px, py);
    close_cross = edge_cross(s1_vx, s1_vy, fx, fy, px, py);
    parity_open = first_item ? 1'b0 : (crossing_parity ^ open_cross);
    parity_close = parity_open ^ close_cross;
    if (first_item) begin
      vertex_count_next = VCOUNT_ONE;
    end else if (vertex_count == VCOUNT_FULL) begin
      vertex_count_next = VCOUNT_FULL;
    end else begin
      vertex_count_next = vertex_count + VCOUNT_ONE;
    end
    polygon_parity_next = polygon_parity ^
                          ((vertex_count_next == VCOUNT_FULL) && parity_close);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      vertex_count    <= VCOUNT_NONE;
      crossing_parity <= 1'b0;
      polygon_parity  <= 1'b0;
      query_open      <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
        s1_qx    <= query_x;
        s1_qy    <= query_y;
        s1_vx    <= vertex_x;
        s1_vy    <= vertex_y;
        s1_lv    <= last_vertex;
        s1_lp    <= last_polygon;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_adv && s1_lv && s1_lp) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (s1_adv) begin
        point_reg_x   <= px;
        point_reg_y   <= py;
        query_open    <= !(s1_lv && s1_lp);
        first_vertex_x <= fx;
        first_vertex_y <= fy;
        prev_vertex_x <= s1_vx;
        prev_vertex_y <= s1_vy;
        if (s1_lv) begin
          vertex_count    <= VCOUNT_NONE;
          crossing_parity <= 1'b0;
          if (s1_lp) begin
            inside_res     <= polygon_parity_next;
            polygon_parity <= 1'b0;
          end else begin
            polygon_parity <= polygon_parity_next;
          end
        end else begin
          vertex_count    <= vertex_count_next;
          crossing_parity <= parity_open;
        end
      end
    end
  end

endmodule
